FILE: design/octree_point_locate_core_defines.svh
// Assertion macros shared by the octree point locate RTL.
// Included by modules that check their own control and datapath behavior.
`ifndef OCTREE_POINT_LOCATE_CORE_DEFINES_SVH
`define OCTREE_POINT_LOCATE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define OPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante
`define OPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define OPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: design/opl_pkg.sv
// Package for the octree point locate core: constants, item and control types.
// No dependencies; used by every module of the block but opl_ram.
`default_nettype none

package opl_pkg;

    localparam int NODE_COUNT  = 4096;
    localparam int NODE_IDX_W  = $clog2(NODE_COUNT);
    localparam int WORD_W      = 32;
    localparam int LEAF_BIT    = 31;
    localparam int COORD_BITS  = 16;
    localparam int DEPTH_W     = 5;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = DEPTH_W'(16);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX       = DEPTH_W'(COORD_BITS);

    // Item modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOCATE = 1'b1;

    // Register word index
    localparam logic REG_DEPTH_LIMIT = 1'b0;

    typedef struct packed {
        logic                  mode;
        logic [11:0]           node_addr;
        logic [WORD_W-1:0]     node_word;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [COORD_BITS-1:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic [11:0]           leaf_index;
        logic [WORD_W-1:0]     leaf_word;
        logic [COORD_BITS-1:0] corner_x;
        logic [COORD_BITS-1:0] corner_y;
        logic [COORD_BITS-1:0] corner_z;
        logic [DEPTH_W-1:0]    cell_depth;
        logic                  depth_error;
    } out_item_t;

    typedef struct packed {
        logic wr;
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic stop;
    } stat_t;

endpackage

`default_nettype wire

FILE: design/octree_point_locate_core.sv
// Octree point location top level; depends on opl_pkg, opl_ctrl, opl_dp and opl_ram.
// A write item is stored as it is accepted. A lookup reads the node table once per level
// through its single read port, and frees the input in the same cycle as its result shows;
// a stalled output holds the walk at its last level.
// The result sits in an output register, so the next item may enter while it waits.
// Reset clears control state and sets depth_limit to 16; the node table is not cleared.
`default_nettype none

module octree_point_locate_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire opl_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output opl_pkg::out_item_t                  out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [opl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [opl_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [opl_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    import opl_pkg::*;

    logic [DEPTH_W-1:0] depth_limit_reg;
    logic [DEPTH_W-1:0] depth_limit_next;
    logic               reg_hit;
    cmd_t               cmd;
    stat_t              stat;

    // Decode the register port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_DEPTH_LIMIT);
    assign prdata  = reg_hit ? APB_DATA_W'(depth_limit_reg) : '0;

    always_comb
    begin
        depth_limit_next = depth_limit_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            depth_limit_next = pwdata[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= DEPTH_LIMIT_RST;
        end
        else
        begin
            depth_limit_reg <= depth_limit_next;
        end
    end

    opl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (in_data.mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    opl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_data     (in_data),
        .depth_limit (depth_limit_reg),
        .stat        (stat),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

FILE: design/opl_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module opl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/opl_ctrl.sv
// Controller for the octree point locate core: item sequencing and output valid.
// Depends on opl_pkg and the assertion macro header.
`default_nettype none
`include "octree_point_locate_core_defines.svh"

module opl_ctrl (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_mode,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output opl_pkg::cmd_t cmd,
    input  wire opl_pkg::stat_t stat
);

    import opl_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_WRITE)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (stat.stop)
                begin
                    if (out_free)
                    begin
                        cmd.finish     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OPL_ASSERT_NEXT(a_finish_shows_result, clk, rst_n, cmd.finish, out_valid_reg, "finish without result")
    `OPL_ASSERT_NEXT(a_start_enters_walk, clk, rst_n, cmd.start, state_reg == ST_WALK, "start lost")
    `OPL_ASSERT_NEXT(a_blocked_result_holds, clk, rst_n, state_reg == ST_WALK && stat.stop && !out_free, state_reg == ST_WALK, "result dropped")

endmodule

`default_nettype wire

FILE: design/opl_dp.sv
// Datapath for the octree point locate core: node table, descent registers, result.
// Depends on opl_pkg, opl_ram and the assertion macro header.
`default_nettype none
`include "octree_point_locate_core_defines.svh"

module opl_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire opl_pkg::cmd_t               cmd,
    input  wire opl_pkg::in_item_t           in_data,
    input  wire logic [opl_pkg::DEPTH_W-1:0] depth_limit,
    output opl_pkg::stat_t                   stat,
    output opl_pkg::out_item_t               out_data
);

    import opl_pkg::*;

    localparam int SHIFT_W = $clog2(COORD_BITS);

    logic [COORD_BITS-1:0] pt_x_reg;
    logic [COORD_BITS-1:0] pt_y_reg;
    logic [COORD_BITS-1:0] pt_z_reg;
    logic [COORD_BITS-1:0] corner_x_reg;
    logic [COORD_BITS-1:0] corner_y_reg;
    logic [COORD_BITS-1:0] corner_z_reg;
    logic [NODE_IDX_W-1:0] idx_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    out_item_t             out_reg;

    logic [WORD_W-1:0]     rdata;
    logic [NODE_IDX_W-1:0] ram_addr;
    logic [NODE_IDX_W-1:0] next_idx;
    logic [DEPTH_W-1:0]    limit_eff;
    logic [SHIFT_W-1:0]    shift_amt;
    logic [COORD_BITS-1:0] half;
    logic [COORD_BITS:0]   mid_x;
    logic [COORD_BITS:0]   mid_y;
    logic [COORD_BITS:0]   mid_z;
    logic                  go_x;
    logic                  go_y;
    logic                  go_z;
    logic                  is_leaf;

    // Clamp the limit to the finest cell
    assign limit_eff = (depth_limit > DEPTH_MAX) ? DEPTH_MAX : depth_limit;
    assign is_leaf   = rdata[LEAF_BIT];
    assign stat.stop = is_leaf || (depth_reg >= limit_eff);

    // Halve the cell and pick the octant above each midpoint
    assign shift_amt = SHIFT_W'(COORD_BITS - 1) - depth_reg[SHIFT_W-1:0];
    assign half      = COORD_BITS'(1) << shift_amt;
    assign mid_x     = {1'b0, corner_x_reg} + {1'b0, half};
    assign mid_y     = {1'b0, corner_y_reg} + {1'b0, half};
    assign mid_z     = {1'b0, corner_z_reg} + {1'b0, half};
    assign go_x      = {1'b0, pt_x_reg} > mid_x;
    assign go_y      = {1'b0, pt_y_reg} > mid_y;
    assign go_z      = {1'b0, pt_z_reg} > mid_z;
    assign next_idx  = rdata[NODE_IDX_W-1:0] + {{(NODE_IDX_W-3){1'b0}}, go_z, go_y, go_x};

    // Select the table address
    always_comb
    begin
        if (cmd.wr)
        begin
            ram_addr = in_data.node_addr[NODE_IDX_W-1:0];
        end
        else if (cmd.start)
        begin
            ram_addr = '0;
        end
        else
        begin
            ram_addr = next_idx;
        end
    end

    opl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr),
        .re    (cmd.start || cmd.step),
        .addr  (ram_addr),
        .wdata (in_data.node_word),
        .rdata (rdata)
    );

    // Track descent depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else if (cmd.start)
        begin
            depth_reg <= '0;
        end
        else if (cmd.step)
        begin
            depth_reg <= depth_reg + DEPTH_W'(1);
        end
    end

    // Hold point, corner and node index of the walk
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pt_x_reg     <= in_data.point_x;
            pt_y_reg     <= in_data.point_y;
            pt_z_reg     <= in_data.point_z;
            corner_x_reg <= '0;
            corner_y_reg <= '0;
            corner_z_reg <= '0;
            idx_reg      <= '0;
        end
        else if (cmd.step)
        begin
            corner_x_reg <= go_x ? mid_x[COORD_BITS-1:0] : corner_x_reg;
            corner_y_reg <= go_y ? mid_y[COORD_BITS-1:0] : corner_y_reg;
            corner_z_reg <= go_z ? mid_z[COORD_BITS-1:0] : corner_z_reg;
            idx_reg      <= next_idx;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.leaf_index  <= 12'(idx_reg);
            out_reg.leaf_word   <= rdata;
            out_reg.corner_x    <= corner_x_reg;
            out_reg.corner_y    <= corner_y_reg;
            out_reg.corner_z    <= corner_z_reg;
            out_reg.cell_depth  <= depth_reg;
            out_reg.depth_error <= !is_leaf;
        end
    end

    assign out_data = out_reg;

    `OPL_ASSERT_IMP(a_depth_bounded, clk, rst_n, 1'b1, depth_reg <= DEPTH_MAX, "depth past finest cell")
    `OPL_ASSERT_NEXT(a_step_deepens, clk, rst_n, cmd.step, depth_reg == $past(depth_reg) + DEPTH_W'(1), "step missed")
    `OPL_ASSERT_IMP(a_step_below_limit, clk, rst_n, cmd.step, depth_reg < limit_eff, "step at limit")

endmodule

`default_nettype wire

FILE: test/octree_point_locate_core_test.sv
// Testbench for octree_point_locate_core: random node-table writes and point lookups,
// checked against an in-bench octree walk. Depends on opl_pkg and the core RTL only.
module octree_point_locate_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import opl_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned PHASE_ITEMS   = 185;
    localparam logic [APB_ADDR_W-1:0] DEPTH_LIMIT_ADDR = APB_ADDR_W'(4 * REG_DEPTH_LIMIT);

    // Mirror of the node table and the lookups still owed by the block
    class locate_scoreboard;
        logic [WORD_W-1:0]  node_words [NODE_COUNT];
        bit                 node_known [NODE_COUNT];
        logic [DEPTH_W-1:0] depth_limit;
        out_item_t          expected_q [$];
        int unsigned        errors;

        function new();
            depth_limit = DEPTH_LIMIT_RST;
            errors      = 0;
        endfunction

        // Walk from the root; return the first unwritten node on the path, else -1
        function automatic int descend(input logic [COORD_BITS-1:0] px, py, pz,
                                       output out_item_t res);
            logic [COORD_BITS-1:0] pt [3];
            int unsigned           corner [3];
            int unsigned           half, off, idx, depth, limit;
            logic [WORD_W-1:0]     word;
            bit                    err;
            pt[0]  = px;
            pt[1]  = py;
            pt[2]  = pz;
            corner = '{0, 0, 0};
            idx    = 0;
            depth  = 0;
            err    = 1'b0;
            res    = '0;
            limit  = (depth_limit > DEPTH_MAX) ? COORD_BITS : depth_limit;
            forever begin
                if (!node_known[idx]) begin
                    res.cell_depth = DEPTH_W'(depth);
                    return int'(idx);
                end
                word = node_words[idx];
                if (word[LEAF_BIT])
                    break;
                if (depth >= limit) begin
                    err = 1'b1;
                    break;
                end
                // Halve the cell; move up on every axis strictly above the midpoint
                half = 1 << (COORD_BITS - 1 - depth);
                off  = 0;
                for (int a = 0; a < 3; a++) begin
                    if (pt[a] > corner[a] + half) begin
                        corner[a] += half;
                        off       += 1 << a;
                    end
                end
                idx = (word[NODE_IDX_W-1:0] + off) % NODE_COUNT;
                depth++;
            end
            res.leaf_index  = idx[NODE_IDX_W-1:0];
            res.leaf_word   = word;
            res.corner_x    = corner[0][COORD_BITS-1:0];
            res.corner_y    = corner[1][COORD_BITS-1:0];
            res.corner_z    = corner[2][COORD_BITS-1:0];
            res.cell_depth  = DEPTH_W'(depth);
            res.depth_error = err;
            return -1;
        endfunction

        function void note_input(input in_item_t it);
            out_item_t res;
            if (it.mode == MODE_WRITE) begin
                node_words[it.node_addr] = it.node_word;
                node_known[it.node_addr] = 1'b1;
            end
            else if (descend(it.point_x, it.point_y, it.point_z, res) < 0)
                expected_q.insert(expected_q.size(), res);
            else begin
                $error("lookup item walks into an unwritten node");
                errors++;
            end
        endfunction

        function void compare(input string field, input logic [WORD_W-1:0] want, got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                $error("result item with no lookup pending: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("leaf_index", want.leaf_index, got.leaf_index);
            compare("leaf_word", want.leaf_word, got.leaf_word);
            compare("corner_x", want.corner_x, got.corner_x);
            compare("corner_y", want.corner_y, got.corner_y);
            compare("corner_z", want.corner_z, got.corner_z);
            compare("cell_depth", want.cell_depth, got.cell_depth);
            compare("depth_error", want.depth_error, got.depth_error);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    locate_scoreboard sb;
    int unsigned      items_sent;
    int unsigned      cycle_count;
    int unsigned      leaf_pct;
    int unsigned      next_block;
    bit               sender_steady;

    octree_point_locate_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input in_item_t it);
        int unsigned gap;
        gap = sender_steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_write(input logic [NODE_IDX_W-1:0] idx, input logic [WORD_W-1:0] word);
        in_item_t it;
        it.mode       = MODE_WRITE;
        it.node_addr  = idx;
        it.node_word  = word;
        it.point_x    = COORD_BITS'($urandom);
        it.point_y    = COORD_BITS'($urandom);
        it.point_z    = COORD_BITS'($urandom);
        send_item(it);
    endtask

    // Pick a node word: a leaf now and then, else an inner node with a child base
    function automatic logic [WORD_W-1:0] make_node(input int unsigned depth);
        logic [WORD_W-1:0] w;
        int unsigned       pick;
        w = $urandom;
        if (depth > 0 && $urandom_range(0, 99) < leaf_pct) begin
            w[LEAF_BIT] = 1'b1;
            return w;
        end
        w[LEAF_BIT] = 1'b0;
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
            w          = WORD_W'(next_block);
            next_block = (next_block + 8) % NODE_COUNT;
        end
        else if (pick == 2)
            w = WORD_W'($urandom_range(0, NODE_COUNT - 1));
        return w;
    endfunction

    // Fill in every unwritten node on the point's path, then look it up
    task automatic probe_point(input logic [COORD_BITS-1:0] x, y, z);
        out_item_t res;
        in_item_t  it;
        int        miss;
        miss = sb.descend(x, y, z, res);
        while (miss >= 0) begin
            send_write(miss[NODE_IDX_W-1:0], make_node(res.cell_depth));
            miss = sb.descend(x, y, z, res);
        end
        it.mode       = MODE_LOCATE;
        it.node_addr  = NODE_IDX_W'($urandom);
        it.node_word  = $urandom;
        it.point_x    = x;
        it.point_y    = y;
        it.point_z    = z;
        send_item(it);
    endtask

    // Let the block run dry before touching its register
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= DEPTH_LIMIT_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata = prdata;
    endtask

    // Write depth_limit and read it back
    task automatic set_depth_limit(input logic [DEPTH_W-1:0] lim);
        logic [APB_DATA_W-1:0] rdata;
        apb_transfer(1'b1, APB_DATA_W'(lim), rdata);
        sb.depth_limit = lim;
        apb_transfer(1'b0, '0, rdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rdata !== APB_DATA_W'(lim)) begin
            $error("depth_limit: expected %0h, got %0h", lim, rdata);
            sb.errors++;
        end
    endtask

    // Accept results after random stalls, with one long hold-off
    initial
    begin : result_sink
        int unsigned gap;
        int unsigned taken;
        bit          steady;
        taken     = 0;
        steady    = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (taken % 40 == 0)
                steady = ($urandom_range(0, 2) == 0);
            gap = steady ? 0 : $urandom_range(0, 7);
            if (taken == 150)
                gap = 400;
            if (gap != 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(out_data);
            taken++;
        end
    end

    initial
    begin : stimulus
        logic [DEPTH_W-1:0]    phase_limits [6];
        logic [COORD_BITS-1:0] focus [3];
        logic [COORD_BITS-1:0] mask;
        int unsigned           start, loops, pick;
        sb            = new();
        items_sent    = 0;
        leaf_pct      = 25;
        next_block    = 16;
        sender_steady = 1'b0;
        phase_limits  = '{5'd0, 5'd1, 5'd31, 5'd4, 5'd8, 5'd16};
        in_valid      <= 1'b0;
        in_data       <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rst_n         <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_depth_limit(DEPTH_LIMIT_RST);

        // Root as a leaf, at both extremes of the cube
        send_write('0, 32'h8000_0000);
        probe_point('0, '0, '0);
        probe_point('1, '1, '1);
        // One level of leaves; midpoint itself stays in the lower octant
        send_write('0, 32'd8);
        for (int i = 0; i < 8; i++)
            send_write(NODE_IDX_W'(8 + i), (i == 7) ? 32'hFFFF_FFFF : {1'b1, 31'(i)});
        probe_point(16'h8000, 16'h8000, 16'h8000);
        probe_point(16'h8001, 16'h8001, 16'h8001);
        probe_point(16'h8001, 16'h0000, 16'hFFFF);
        // Child base that wraps past the end of the table
        send_write(NODE_IDX_W'(15), 32'h7FFF_FFFC);
        probe_point('1, '1, '1);
        // Self-referencing nodes run into the depth limit at full depth
        send_write('0, 32'd0);
        send_write(NODE_IDX_W'(7), 32'd0);
        probe_point('1, '1, '1);
        probe_point('0, '0, '0);
        drain();

        for (int p = 0; p < 6; p++) begin
            set_depth_limit((p == 4) ? DEPTH_W'($urandom_range(1, 16)) : phase_limits[p]);
            leaf_pct = (p % 2 == 1) ? 4 : 25;
            // Start a fresh tree at the root
            send_write('0, make_node(0));
            start = items_sent;
            loops = 0;
            while (items_sent - start < PHASE_ITEMS) begin
                if (loops % 40 == 0) begin
                    sender_steady = ($urandom_range(0, 3) == 0);
                    for (int a = 0; a < 3; a++)
                        focus[a] = COORD_BITS'($urandom);
                end
                loops++;
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // Overwrite some node, near the root or anywhere
                    if ($urandom_range(0, 1) == 0)
                        send_write(NODE_IDX_W'($urandom_range(1, 15)), $urandom);
                    else
                        send_write(NODE_IDX_W'($urandom), $urandom);
                end
                else if (pick < 60) begin
                    // Stay near the focus so that deep paths are reused
                    mask = COORD_BITS'((32'd1 << $urandom_range(0, COORD_BITS)) - 1);
                    probe_point(focus[0] ^ (COORD_BITS'($urandom) & mask),
                                focus[1] ^ (COORD_BITS'($urandom) & mask),
                                focus[2] ^ (COORD_BITS'($urandom) & mask));
                end
                else
                    probe_point(COORD_BITS'($urandom), COORD_BITS'($urandom),
                                COORD_BITS'($urandom));
            end
            drain();
        end

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
